// File: hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // supported width of the payload length
  localparam int unsigned LenBits = 32;

  // first header byte codes
  localparam logic [7:0] HdrText  = 8'h81;
  localparam logic [7:0] HdrClose = 8'h88;

  // second header byte
  localparam logic [7:0] LenMask  = 8'h7F;
  localparam logic [7:0] MaskBit  = 8'h80;
  localparam logic [6:0] Len16    = 7'd126;
  localparam logic [6:0] Len64    = 7'd127;

  // extended length and mask key byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // parser phases
  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhClosed  = 3'd5;

  // result kinds
  localparam logic [1:0] StData   = 2'd0;
  localparam logic [1:0] StEmpty  = 2'd1;
  localparam logic [1:0] StClose  = 2'd2;
  localparam logic [1:0] StReject = 2'd3;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
// channel   direction  ports                  contents
// rx bytes  in         s_axis_*               tdata[7:0] rx_byte
// results   out        m_axis_*               tdata[7:0] payload_byte, tuser[1:0] status,
//                                             tlast last_of_message
//
// one received byte is taken every cycle unless the result side stalls
// the parser state updates in the same cycle the byte is accepted, the result lands
// in a single output register that can be reloaded while it is being drained
// a stall on the result side holds s_axis_tready low only while that register is full
// and not taken
// rst_ni clears the parser to expect a first header byte and empties the output
// register; after a close or reject all bytes are swallowed until reset
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [1:0] m_axis_tuser,   // [1:0] status
  output logic       m_axis_tlast    // last_of_message
);

  localparam int unsigned LenBits = wsd_pkg::LenBits;

  // parser state
  logic [2:0]         phase_q, phase_d;
  logic [3:0]         cnt_q, cnt_d;       // extended length or mask key bytes left
  logic [LenBits-1:0] len_q, len_d;       // payload length, then payload bytes left
  logic               mask_q, mask_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         pos_q, pos_d;       // mask key byte position

  // output register
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       accept;
  logic       res_valid;
  logic [1:0] res_status;
  logic [7:0] res_byte;
  logic       res_last;
  logic       after_len;
  logic       start_pl;
  logic [7:0] key_byte;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // key byte for this payload position, most significant first
  assign key_byte = key_q[{~pos_q, 3'b000} +: 8];

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    mask_d     = mask_q;
    key_d      = key_q;
    pos_d      = pos_q;
    res_valid  = 1'b0;
    res_status = wsd_pkg::StData;
    res_byte   = 8'h00;
    res_last   = 1'b0;
    after_len  = 1'b0;
    start_pl   = 1'b0;

    case (phase_q)
      wsd_pkg::PhHdr0: begin
        if (s_axis_tdata == wsd_pkg::HdrText) begin
          phase_d = wsd_pkg::PhHdr1;
        end else begin
          phase_d    = wsd_pkg::PhClosed;
          res_valid  = 1'b1;
          res_status = (s_axis_tdata == wsd_pkg::HdrClose) ? wsd_pkg::StClose
                                                           : wsd_pkg::StReject;
        end
      end
      wsd_pkg::PhHdr1: begin
        mask_d = |(s_axis_tdata & wsd_pkg::MaskBit);
        len_d  = '0;
        if ((s_axis_tdata & wsd_pkg::LenMask) == {1'b0, wsd_pkg::Len16}) begin
          cnt_d   = wsd_pkg::ExtBytes16;
          phase_d = wsd_pkg::PhExtLen;
        end else if ((s_axis_tdata & wsd_pkg::LenMask) == {1'b0, wsd_pkg::Len64}) begin
          cnt_d   = wsd_pkg::ExtBytes64;
          phase_d = wsd_pkg::PhExtLen;
        end else begin
          len_d     = {{(LenBits-7){1'b0}}, s_axis_tdata[6:0]};
          after_len = 1'b1;
        end
      end
      wsd_pkg::PhExtLen: begin
        if (len_q[LenBits-1 -: 8] != 8'h00) begin
          // length does not fit the supported width
          phase_d    = wsd_pkg::PhClosed;
          res_valid  = 1'b1;
          res_status = wsd_pkg::StReject;
        end else begin
          len_d     = {len_q[LenBits-9:0], s_axis_tdata};
          cnt_d     = cnt_q - 4'd1;
          after_len = (cnt_q == 4'd1);
        end
      end
      wsd_pkg::PhMask: begin
        key_d    = {key_q[23:0], s_axis_tdata};
        cnt_d    = cnt_q - 4'd1;
        start_pl = (cnt_q == 4'd1);
      end
      wsd_pkg::PhPayload: begin
        pos_d     = pos_q + 2'd1;
        len_d     = len_q - LenBits'(1);
        res_valid = 1'b1;
        res_byte  = s_axis_tdata ^ key_byte;
        res_last  = (len_q == LenBits'(1));
        if (res_last) begin
          phase_d = wsd_pkg::PhHdr0;
        end
      end
      wsd_pkg::PhClosed: begin
        phase_d = wsd_pkg::PhClosed;
      end
      default: begin
        phase_d = wsd_pkg::PhClosed;
      end
    endcase

    // length known: fetch the mask key or go straight to the payload
    if (after_len) begin
      key_d = '0;
      if (mask_d) begin
        cnt_d   = wsd_pkg::KeyBytes;
        phase_d = wsd_pkg::PhMask;
      end else begin
        start_pl = 1'b1;
      end
    end

    // header complete: empty message or payload
    if (start_pl) begin
      pos_d = 2'd0;
      if (len_d == '0) begin
        phase_d    = wsd_pkg::PhHdr0;
        res_valid  = 1'b1;
        res_status = wsd_pkg::StEmpty;
        res_last   = 1'b1;
      end else begin
        phase_d = wsd_pkg::PhPayload;
      end
    end
  end

  assign out_valid_d = (accept && res_valid) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PhHdr0;
      cnt_q       <= '0;
      len_q       <= '0;
      mask_q      <= 1'b0;
      key_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        mask_q  <= mask_d;
        key_q   <= key_d;
        pos_q   <= pos_d;
      end
    end
  end

  // result payload, loaded with each request that yields a result
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_status_q <= res_status;
      out_byte_q   <= res_byte;
      out_last_q   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // one parsed result: status in tuser, unmasked byte in tdata, tlast
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  // directed row: request byte, whether the result is typed in, and that result
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    frame_out_t want;
  } dir_row_t;

  localparam frame_out_t NoRes      = '0;
  localparam int unsigned RandBytes = 850;
  localparam int unsigned MaxGap    = 13;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned DrainLen  = 16;
  localparam int unsigned CycleLimit = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] payload_byte
  logic [1:0] m_axis_tuser;   // [1:0] status
  logic       m_axis_tlast;   // last_of_message

  websocket_frame_deframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // parser state as the predictor sees it
  logic [2:0]                  ph        = wsd_pkg::PhHdr0;
  logic [3:0]                  len_left  = '0;
  logic [wsd_pkg::LenBits-1:0] plen      = '0;
  logic                        mflag     = 1'b0;
  logic [2:0]                  key_left  = '0;
  logic [31:0]                 key       = '0;
  logic [wsd_pkg::LenBits-1:0] pay_left  = '0;
  logic [1:0]                  key_pos   = '0;

  frame_out_t  result_q[$];     // results still owed by the block
  int unsigned fails        = 0;
  int unsigned cycle_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned hold_cycles  = 0;
  bit          burst        = 1'b0;
  bit          cur_typed    = 1'b0;
  frame_out_t  cur_want     = '0;
  dir_row_t    dir_rows [25];

  always #1 clk_i = ~clk_i;

  // header finished: empty message right away, else payload follows
  function automatic bit open_payload(output frame_out_t r);
    r = NoRes;
    key_pos = '0;
    if (plen == '0) begin
      ph = wsd_pkg::PhHdr0;
      r.status = wsd_pkg::StEmpty;
      r.last = 1'b1;
      return 1'b1;
    end
    pay_left = plen;
    ph = wsd_pkg::PhPayload;
    return 1'b0;
  endfunction

  // length known: mask key next if flagged
  function automatic bit length_known(output frame_out_t r);
    r = NoRes;
    key = '0;
    if (mflag) begin
      key_left = 3'(wsd_pkg::KeyBytes);
      ph = wsd_pkg::PhMask;
      return 1'b0;
    end
    return open_payload(r);
  endfunction

  // advance the parser by one byte, returns 1 when a result comes out
  function automatic bit parse_byte(input logic [7:0] b, output frame_out_t r);
    logic [7:0] kb;
    r = NoRes;
    case (ph)
      wsd_pkg::PhHdr0: begin
        if (b == wsd_pkg::HdrText) begin
          ph = wsd_pkg::PhHdr1;
          return 1'b0;
        end
        ph = wsd_pkg::PhClosed;
        r.status = (b == wsd_pkg::HdrClose) ? wsd_pkg::StClose : wsd_pkg::StReject;
        return 1'b1;
      end
      wsd_pkg::PhHdr1: begin
        mflag = b[7];
        plen = '0;
        if (b[6:0] == wsd_pkg::Len16) begin
          len_left = wsd_pkg::ExtBytes16;
          ph = wsd_pkg::PhExtLen;
          return 1'b0;
        end
        if (b[6:0] == wsd_pkg::Len64) begin
          len_left = wsd_pkg::ExtBytes64;
          ph = wsd_pkg::PhExtLen;
          return 1'b0;
        end
        plen = wsd_pkg::LenBits'(b[6:0]);
        return length_known(r);
      end
      wsd_pkg::PhExtLen: begin
        // another byte would push the length past the supported width
        if (plen[wsd_pkg::LenBits-1 -: 8] != 8'h00) begin
          ph = wsd_pkg::PhClosed;
          r.status = wsd_pkg::StReject;
          return 1'b1;
        end
        plen = {plen[wsd_pkg::LenBits-9:0], b};
        len_left = len_left - 4'd1;
        if (len_left == 4'd0) return length_known(r);
        return 1'b0;
      end
      wsd_pkg::PhMask: begin
        key = {key[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) return open_payload(r);
        return 1'b0;
      end
      wsd_pkg::PhPayload: begin
        kb = key[8 * (3 - int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        pay_left = pay_left - 1'b1;
        r.status = wsd_pkg::StData;
        r.data = b ^ kb;
        r.last = (pay_left == '0);
        if (r.last) ph = wsd_pkg::PhHdr0;
        return 1'b1;
      end
      default: begin
        ph = wsd_pkg::PhClosed;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic log_fail(input string what, input frame_out_t want, input frame_out_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0s at cycle %0d: expected status %0d data %02h last %0d,",
               what, cycle_count, want.status, want.data, want.last);
      $display("  got status %0d data %02h last %0d", got.status, got.data, got.last);
    end
  endtask

  // offer one request byte; entered and left at a falling edge
  task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                         input frame_out_t want = '0);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // one well formed final text frame; form 0 short length, 1 16-bit, 2 64-bit
  task automatic send_frame(input int unsigned len, input bit masked, input int unsigned form);
    logic [6:0]  len7;
    logic [63:0] ext;
    int          n;
    ext = 64'(len);
    case (form)
      1:       begin len7 = wsd_pkg::Len16; n = 2; end
      2:       begin len7 = wsd_pkg::Len64; n = 8; end
      default: begin len7 = 7'(len); n = 0; end
    endcase
    send_rx(wsd_pkg::HdrText);
    send_rx({masked, len7});
    for (int i = n - 1; i >= 0; i--) send_rx(ext[8*i +: 8]);
    if (masked) repeat (4) send_rx(8'($urandom_range(0, 255)));
    repeat (len) send_rx(8'($urandom_range(0, 255)));
  endtask

  // scoreboard: both handshakes seen at the same rising edge, request side first
  always @(posedge clk_i) begin : scoreboard
    frame_out_t pred;
    frame_out_t got;
    frame_out_t want;
    bit         has;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        has = parse_byte(s_axis_tdata, pred);
        if (cur_typed) begin
          has = 1'b1;
          pred = cur_want;
        end
        if (has) result_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: m_axis_tuser, data: m_axis_tdata, last: m_axis_tlast};
        if (result_q.size() == 0) begin
          log_fail("unexpected result", NoRes, got);
        end else begin
          want = result_q.pop_front();
          if (got.status != want.status || got.data != want.data || got.last != want.last)
            log_fail("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, a long hold-off when asked for
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, MaxGap);
        if (stall != 0) begin
          m_axis_tready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int unsigned frames;
    int unsigned len;
    int unsigned form;
    int unsigned pick;
    logic [7:0]  b;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;

    dir_rows = '{
      // empty frame, result on the length byte
      {wsd_pkg::HdrText, 1'b0, NoRes},
      {8'h00, 1'b1, {wsd_pkg::StEmpty, 8'h00, 1'b1}},
      // two unmasked bytes at the extremes
      {wsd_pkg::HdrText, 1'b0, NoRes},
      {8'h02, 1'b0, NoRes},
      {8'h00, 1'b1, {wsd_pkg::StData, 8'h00, 1'b0}},
      {8'hFF, 1'b1, {wsd_pkg::StData, 8'hFF, 1'b1}},
      // masked frame with a 16-bit length of one
      {wsd_pkg::HdrText, 1'b0, NoRes},
      {{1'b1, wsd_pkg::Len16}, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h01, 1'b0, NoRes},
      {8'hA5, 1'b0, NoRes},
      {8'h5A, 1'b0, NoRes},
      {8'h0F, 1'b0, NoRes},
      {8'hF0, 1'b0, NoRes},
      {8'hFF, 1'b0, NoRes},
      // 64-bit length of zero, result on the last length byte
      {wsd_pkg::HdrText, 1'b0, NoRes},
      {{1'b0, wsd_pkg::Len64}, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b0, NoRes},
      {8'h00, 1'b1, {wsd_pkg::StEmpty, 8'h00, 1'b1}}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_rx(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

    // random frames; a close of any kind is final, so it only comes at the end
    bytes_sent = 0;
    frames = 0;
    while (bytes_sent < RandBytes) begin
      burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) len = $urandom_range(0, 6);
      else if (pick < 80) len = $urandom_range(7, 40);
      else if (pick < 90) len = $urandom_range(41, 125);
      else len = $urandom_range(0, 300);
      form = (len > 125) ? $urandom_range(1, 2) : (pick >= 90 ? $urandom_range(0, 2) : 0);
      if (frames == 12) begin
        // receiver holds off while bytes keep coming, input must back up
        burst = 1'b1;
        hold_cycles = HoldLen;
        len = 60;
        form = 0;
      end
      if (frames == 25) begin
        // sender waits until the block has handed over everything
        while (result_q.size() != 0) @(negedge clk_i);
      end
      send_frame(len, 1'($urandom_range(0, 1)), form);
      frames++;
    end
    burst = 1'b0;

    // closing request: peer close, reject or length overflow
    case ($urandom_range(0, 2))
      0: send_rx(wsd_pkg::HdrClose);
      1: begin
        if ($urandom_range(0, 1) != 0) begin
          b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == wsd_pkg::HdrText || b == wsd_pkg::HdrClose);
        end
        send_rx(b);
      end
      default: begin
        send_rx(wsd_pkg::HdrText);
        send_rx({1'($urandom_range(0, 1)), wsd_pkg::Len64});
        send_rx(8'($urandom_range(1, 255)));
        repeat (7) send_rx(8'($urandom_range(0, 255)));
      end
    endcase
    // closed: a valid looking frame must now be swallowed
    send_rx(wsd_pkg::HdrText);
    send_rx(8'h00);
    send_rx(wsd_pkg::HdrText);
    send_rx(8'h01);
    send_rx(8'h41);
    s_axis_tvalid = 1'b0;

    while (result_q.size() != 0) @(negedge clk_i);
    repeat (DrainLen) @(negedge clk_i);
    if (result_q.size() != 0) begin
      fails += result_q.size();
      $display("%0d results never arrived", result_q.size());
    end
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
